### sv/bsh_pkg.sv
// Shared types and constants for the subsampled Bayer histogram block.
// Used by the position tracker, the modulo unit, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsh_pkg;

  // Request codes
  localparam logic [1:0] REQ_FRAME_BYTE = 2'd0;
  localparam logic [1:0] REQ_READ_BIN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR      = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAIR_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_PAIR_ROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAIR_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_PAIR_COL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSAMPLE_STEP = 3'd5;

  // Field and state widths
  localparam int LINE_BYTES_W = 16;
  localparam int PAIR_W       = 12;
  localparam int STEP_W       = 8;
  localparam int PCOL_W       = 15;  // byte position / 3
  localparam int LINE_W       = 13;
  localparam int SUB_W        = 2;
  localparam int OUT_CNT_W    = 16;
  localparam int MOD_STAGES   = 3;

  // Byte position within a three-byte group
  localparam logic [SUB_W-1:0] SUB_MSB_FIRST  = 2'd0;
  localparam logic [SUB_W-1:0] SUB_MSB_SECOND = 2'd1;
  localparam logic [SUB_W-1:0] SUB_LSB        = 2'd2;

  // Register reset values
  localparam logic [LINE_BYTES_W-1:0] RST_LINE_BYTES     = 16'd5800;
  localparam logic [PAIR_W-1:0]       RST_FIRST_PAIR_ROW = 12'd20;
  localparam logic [PAIR_W-1:0]       RST_END_PAIR_ROW   = 12'd1100;
  localparam logic [PAIR_W-1:0]       RST_FIRST_PAIR_COL = 12'd6;
  localparam logic [PAIR_W-1:0]       RST_END_PAIR_COL   = 12'd1926;
  localparam logic [STEP_W-1:0]       RST_SUBSAMPLE_STEP = 8'd16;

  typedef struct packed {
    logic [1:0] req_type;
    logic       frame_start;
    logic [7:0] data_byte;
    logic [1:0] read_channel;
    logic [7:0] read_bin;
  } req_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] bin_count;
    logic [1:0]           out_channel;
    logic [7:0]           out_bin;
  } rsp_t;

  typedef struct packed {
    logic [LINE_BYTES_W-1:0] line_bytes;
    logic [PAIR_W-1:0]       first_pair_row;
    logic [PAIR_W-1:0]       end_pair_row;
    logic [PAIR_W-1:0]       first_pair_col;
    logic [PAIR_W-1:0]       end_pair_col;
    logic [STEP_W-1:0]       subsample_step;
  } cfg_t;

  // Window status of the byte at the head of the request channel
  typedef struct packed {
    logic              row_in;
    logic              col_in;
    logic [SUB_W-1:0]  sub;
    logic              odd_line;
    logic [PAIR_W-1:0] row_diff;
    logic [PAIR_W-1:0] col_diff;
  } pos_t;

endpackage

`default_nettype wire

### sv/bayer_subsampled_histogram.sv
// Top level of the subsampled Bayer histogram: config registers, request pipeline,
// bin RAM with read-modify-write and the response register.
// Uses bsh_pkg, bsh_pos, bsh_mod and bsh_ram.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_t (frame byte, bin read, clear)
//   rsp       out        rsp_valid/rsp_ready  rsp_t (one per bin read)
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// One request per cycle while req_ready is high; a sweep, a pending clear or a stall
// lowers it. A bin read passes the three step remainder stages, then the RAM read,
// registered with the entry in the write/forward stage that loads the result register.
// After reset, and after a clear request once the pipeline has drained, all 4*HIST_BINS
// bin RAM entries are swept to zero with req_ready low; config writes are still taken.
// A read waiting in the last stage behind an untaken result stalls the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module bayer_subsampled_histogram import bsh_pkg::*; #(
  parameter int HIST_BINS   = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BIN_W  = $clog2(HIST_BINS);
  localparam int DEPTH  = 4 * HIST_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = BIN_W + 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef struct packed {
    logic              is_read;
    logic              is_cand;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        ch;
    logic [7:0]        bin;
  } stage_t;

  cfg_t cfg;
  pos_t pos;

  logic accept, adv, hold, pipe_empty;
  logic sweeping, clr_pending;
  logic [ADDR_W-1:0] sweep_addr;

  logic [BIN_W-1:0]  rbin_tab [256];
  logic [BIN_W-1:0]  rbin, bump_bin;
  logic [PROD_W-1:0] bump_prod;

  stage_t ent;
  logic   ent_v;
  stage_t pipe [MOD_STAGES];
  logic [MOD_STAGES-1:0] pipe_v;
  stage_t last;
  logic   access;
  stage_t w;
  logic   w_v;

  logic [STEP_W:0]   step;
  logic [STEP_W-1:0] row_rem, col_rem;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                   lw_v;
  logic [ADDR_W-1:0]      lw_addr;
  logic [COUNT_WIDTH-1:0] lw_data;
  logic [COUNT_WIDTH-1:0] cur, inc;
  logic                   bump_we, load;
  logic [OUT_CNT_W-1:0]   cnt_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_bytes     <= RST_LINE_BYTES;
      cfg.first_pair_row <= RST_FIRST_PAIR_ROW;
      cfg.end_pair_row   <= RST_END_PAIR_ROW;
      cfg.first_pair_col <= RST_FIRST_PAIR_COL;
      cfg.end_pair_col   <= RST_END_PAIR_COL;
      cfg.subsample_step <= RST_SUBSAMPLE_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_BYTES:     cfg.line_bytes     <= cfg_data;
        REG_FIRST_PAIR_ROW: cfg.first_pair_row <= cfg_data[PAIR_W-1:0];
        REG_END_PAIR_ROW:   cfg.end_pair_row   <= cfg_data[PAIR_W-1:0];
        REG_FIRST_PAIR_COL: cfg.first_pair_col <= cfg_data[PAIR_W-1:0];
        REG_END_PAIR_COL:   cfg.end_pair_col   <= cfg_data[PAIR_W-1:0];
        REG_SUBSAMPLE_STEP: cfg.subsample_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stall
  assign hold       = w_v && w.is_read && rsp_valid && !rsp_ready;
  assign adv        = !hold;
  assign pipe_empty = (pipe_v == '0) && !w_v;
  assign req_ready  = adv && !sweeping && !clr_pending;
  assign accept     = req_valid && req_ready;

  bsh_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept && (req.req_type == REQ_FRAME_BYTE)),
    .frame_start (req.frame_start),
    .cfg         (cfg),
    .pos         (pos)
  );

  // Read index modulo the bin count, as a constant table
  for (genvar i = 0; i < 256; i++) begin : g_rbin
    assign rbin_tab[i] = BIN_W'(i % HIST_BINS);
  end
  assign rbin = rbin_tab[req.read_bin];

  assign bump_prod = PROD_W'(req.data_byte) * PROD_W'(HIST_BINS);
  assign bump_bin  = bump_prod[PROD_W-1:8];

  always_comb begin
    ent.is_read = (req.req_type == REQ_READ_BIN);
    ent.is_cand = (req.req_type == REQ_FRAME_BYTE) && pos.row_in && pos.col_in &&
                  (pos.sub != SUB_LSB);
    ent.ch      = ent.is_read ? req.read_channel : {pos.odd_line, pos.sub[0]};
    ent.bin     = 8'(rbin);
    ent.addr    = ADDR_W'(ent.ch) * ADDR_W'(HIST_BINS) +
                  (ent.is_read ? ADDR_W'(rbin) : ADDR_W'(bump_bin));
  end
  assign ent_v = accept && (ent.is_read || ent.is_cand);

  // Step zero acts as 256
  assign step = {(cfg.subsample_step == '0), cfg.subsample_step};

  bsh_mod u_row_mod (
    .clk      (clk),
    .en       (adv),
    .dividend (pos.row_diff),
    .divisor  (step),
    .rem      (row_rem)
  );

  bsh_mod u_col_mod (
    .clk      (clk),
    .en       (adv),
    .dividend (pos.col_diff),
    .divisor  (step),
    .rem      (col_rem)
  );

  // Request pipeline, aligned with the remainder unit stages
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (adv) begin
      pipe_v <= {pipe_v[MOD_STAGES-2:0], ent_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= ent;
      for (int i = 1; i < MOD_STAGES; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign last   = pipe[MOD_STAGES-1];
  assign access = pipe_v[MOD_STAGES-1] &&
                  (last.is_read || (last.is_cand && (row_rem == '0) && (col_rem == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v <= 1'b0;
    end else if (adv) begin
      w_v <= access;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w <= last;
    end
  end

  // Forward the write made while this entry was being read
  assign cur     = (lw_v && (lw_addr == w.addr)) ? lw_data : ram_rdata;
  assign inc     = (cur == COUNT_MAX) ? cur : cur + 1'b1;
  assign bump_we = adv && w_v && !w.is_read;

  assign ram_we    = sweeping || bump_we;
  assign ram_waddr = sweeping ? sweep_addr : w.addr;
  assign ram_wdata = sweeping ? '0 : inc;

  bsh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (last.addr),
    .rdata (ram_rdata)
  );

  // Clearing sweep: drain first, then zero one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping    <= 1'b1;
      sweep_addr  <= '0;
      clr_pending <= 1'b0;
      lw_v        <= 1'b0;
    end else begin
      if (sweeping) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          sweeping <= 1'b0;
        end
      end else if (clr_pending && pipe_empty) begin
        sweeping    <= 1'b1;
        sweep_addr  <= '0;
        clr_pending <= 1'b0;
      end else if (accept && (req.req_type == REQ_CLEAR)) begin
        clr_pending <= 1'b1;
      end
      if (sweeping) begin
        lw_v <= 1'b0;
      end else if (bump_we) begin
        lw_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bump_we) begin
      lw_addr <= w.addr;
      lw_data <= inc;
    end
  end

  // Clamp the count to the result field
  if (COUNT_WIDTH > OUT_CNT_W) begin : g_clamp
    assign cnt_out = (cur > COUNT_WIDTH'({OUT_CNT_W{1'b1}})) ? {OUT_CNT_W{1'b1}} :
                     cur[OUT_CNT_W-1:0];
  end else begin : g_extend
    assign cnt_out = OUT_CNT_W'(cur);
  end

  assign load = adv && w_v && w.is_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.bin_count   <= cnt_out;
      rsp.out_channel <= w.ch;
      rsp.out_bin     <= w.bin;
    end
  end

endmodule

`default_nettype wire

### sv/bsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module bsh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/bsh_pos.sv
// Frame position tracker: byte in line, pair column, group byte and line in frame.
// Reports window membership and offsets from the window origin. Uses bsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsh_pos import bsh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic frame_start,
  input  cfg_t cfg,
  output pos_t pos
);

  logic [LINE_BYTES_W-1:0] byte_in_line, byte_in_line_next, cur_byte;
  logic [PCOL_W-1:0]       pair_col, pair_col_next, cur_col;
  logic [SUB_W-1:0]        sub, sub_next, cur_sub;
  logic [LINE_W-1:0]       line_in_frame, line_in_frame_next, cur_line;
  logic [PAIR_W-1:0]       pair_row;
  logic [LINE_BYTES_W:0]   line_len;
  logic                    line_end;

  // A frame start byte sits at line 0, byte 0
  assign cur_byte = frame_start ? '0 : byte_in_line;
  assign cur_col  = frame_start ? '0 : pair_col;
  assign cur_sub  = frame_start ? SUB_MSB_FIRST : sub;
  assign cur_line = frame_start ? '0 : line_in_frame;

  assign pair_row = cur_line[LINE_W-1:1];
  // zero length means 65536
  assign line_len = {(cfg.line_bytes == '0), cfg.line_bytes};
  assign line_end = ({1'b0, cur_byte} + 1'b1) >= line_len;

  always_comb begin
    if (line_end) begin
      byte_in_line_next  = '0;
      pair_col_next      = '0;
      sub_next           = SUB_MSB_FIRST;
      line_in_frame_next = (cur_line == '1) ? cur_line : cur_line + 1'b1;
    end else begin
      byte_in_line_next  = cur_byte + 1'b1;
      line_in_frame_next = cur_line;
      if (cur_sub == SUB_LSB) begin
        sub_next      = SUB_MSB_FIRST;
        pair_col_next = cur_col + 1'b1;
      end else begin
        sub_next      = cur_sub + 1'b1;
        pair_col_next = cur_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_line  <= '0;
      pair_col      <= '0;
      sub           <= SUB_MSB_FIRST;
      line_in_frame <= '0;
    end else if (advance) begin
      byte_in_line  <= byte_in_line_next;
      pair_col      <= pair_col_next;
      sub           <= sub_next;
      line_in_frame <= line_in_frame_next;
    end
  end

  assign pos.row_in   = (pair_row >= cfg.first_pair_row) && (pair_row < cfg.end_pair_row);
  assign pos.col_in   = (cur_col >= PCOL_W'(cfg.first_pair_col)) &&
                        (cur_col < PCOL_W'(cfg.end_pair_col));
  assign pos.sub      = cur_sub;
  assign pos.odd_line = cur_line[0];
  assign pos.row_diff = pair_row - cfg.first_pair_row;
  // only meaningful inside the window, where the column fits in PAIR_W bits
  assign pos.col_diff = cur_col[PAIR_W-1:0] - cfg.first_pair_col;

endmodule

`default_nettype wire

### sv/bsh_mod.sv
// Pipelined restoring remainder unit: a PAIR_W-bit offset modulo the step.
// MOD_STAGES register stages, PAIR_W / MOD_STAGES quotient bits each. Uses bsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsh_mod import bsh_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PAIR_W-1:0] dividend,
  input  logic [STEP_W:0]   divisor,
  output logic [STEP_W-1:0] rem
);

  localparam int BPS = PAIR_W / MOD_STAGES;

  logic [STEP_W-1:0] rem_q [MOD_STAGES];
  logic [PAIR_W-1:0] div_q [MOD_STAGES-1];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
    logic [STEP_W-1:0] r_in;
    logic [PAIR_W-1:0] d_in;
    logic [STEP_W-1:0] r_out;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign d_in = dividend;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign d_in = div_q[s-1];
    end

    always_comb begin
      logic [PAIR_W-1:0] sh;
      logic [STEP_W:0]   t;
      sh    = d_in << (s * BPS);
      r_out = r_in;
      for (int j = 0; j < BPS; j++) begin
        t = {r_out, sh[PAIR_W-1]};
        if (t >= divisor) begin
          t = t - divisor;
        end
        r_out = t[STEP_W-1:0];
        sh    = sh << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= r_out;
      end
    end

    if (s < MOD_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          div_q[s] <= d_in;
        end
      end
    end
  end

  assign rem = rem_q[MOD_STAGES-1];

endmodule

`default_nettype wire

### sv/bsh_checker.sv
// Port-level checker for the subsampled Bayer histogram, bound to the top level.
// Uses bsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsh_checker import bsh_pkg::*; #(
  parameter int HIST_BINS = 256
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // The bin RAM is swept after reset before any request is taken
  a_sweep_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken straight after reset");

  // A clear transfer blocks the request channel until the sweep is done; the check covers its start
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.req_type == REQ_CLEAR)) |=> !req_ready)
    else $error("request taken right after a clear transfer");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("result dropped or changed while stalled");

  // Returned bin lies within the histogram
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.out_bin) < HIST_BINS))
    else $error("returned bin beyond histogram");

endmodule

bind bayer_subsampled_histogram bsh_checker #(.HIST_BINS(HIST_BINS)) u_bsh_checker (.*);

`default_nettype wire
